### src/uvsg_pkg.sv
package uvsg_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SEGMENT_COUNT = 2'd0;
    localparam logic [1:0] REG_RING_COUNT    = 2'd1;
    localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

    // CORDIC step count, and angle and CORDIC constants in Q2.30.
    localparam int                 CORDIC_STEPS    = 24;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0]        HALF_PI_Q30     = 31'd1686629713;

    // Pipeline stage counts of the three sections.
    localparam int DIV_STAGES    = 9;
    localparam int CORDIC_STAGES = 9;
    localparam int SHADE_STAGES  = 4;
    localparam int PIPE_STAGES   = DIV_STAGES + CORDIC_STAGES + SHADE_STAGES;

    // Per-item data that rides beside the arithmetic.
    typedef struct packed {
        logic [15:0] vertex_number;
        logic [15:0] lower_row_number;
        logic        starts_quad;
        logic        out_of_range;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } uvsg_side_t;

    // Truncated arctangent table, one entry per CORDIC step.
    function automatic logic signed [33:0] atan_q30(input int step);
        logic signed [33:0] a;
        case (step)
            0:       a = 34'sd843314856;
            1:       a = 34'sd497837829;
            2:       a = 34'sd263043836;
            3:       a = 34'sd133525158;
            4:       a = 34'sd67021686;
            5:       a = 34'sd33543515;
            6:       a = 34'sd16775850;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194282;
            9:       a = 34'sd2097149;
            10:      a = 34'sd1048575;
            11:      a = 34'sd524287;
            12:      a = 34'sd262143;
            13:      a = 34'sd131071;
            14:      a = 34'sd65535;
            15:      a = 34'sd32767;
            16:      a = 34'sd16383;
            17:      a = 34'sd8191;
            18:      a = 34'sd4095;
            19:      a = 34'sd2047;
            20:      a = 34'sd1023;
            21:      a = 34'sd511;
            22:      a = 34'sd255;
            23:      a = 34'sd127;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

    // Saturate a signed value to Q1.15.
    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767)
            r = 16'sh7FFF;
        else if (v < -34'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Saturate a signed value to 24 bits.
    function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
        logic signed [23:0] r;
        if (v > 34'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -34'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

### src/uvsg_div.sv
// Rounded fixed-point quotient numer * 2^FRAC / denom, one quotient bit per
// step, four steps per stage. The Q1.16 quotient is taken on the way.
module uvsg_div #(
    parameter int FRAC = 32
) (
    input  logic                                clk,
    input  logic [uvsg_pkg::DIV_STAGES-1:0]     stage_en,
    input  logic [7:0]                          numer,
    input  logic [7:0]                          denom,
    output logic [31:0]                         angle,
    output logic [16:0]                         tex
);

    localparam int SKIP = 32 - FRAC;
    localparam int STG  = uvsg_pkg::DIV_STAGES - 1;

    logic [7:0]  r_reg   [STG];
    logic [32:0] q_reg   [STG];
    logic [16:0] tex_reg [STG];
    logic [31:0] angle_reg;
    logic [16:0] tex_out_reg;
    logic [7:0]  half_up;

    // Remainder threshold at which the quotient rounds up.
    assign half_up = denom - (denom >> 1);

    genvar s;
    generate
        for (s = 0; s < STG; s++)
        begin : g_stage
            logic [7:0]  r_next;
            logic [32:0] q_next;
            logic [16:0] tex_next;

            // The integer bit first, then four quotient steps in every stage.
            always_comb
            begin
                logic [8:0] t;
                logic       b;
                t = '0;
                b = 1'b0;
                if (s == 0)
                begin
                    b        = numer >= denom;
                    r_next   = b ? numer - denom : numer;
                    q_next   = {32'd0, b};
                    tex_next = '0;
                end
                else
                begin
                    r_next   = r_reg[(s > 0) ? s - 1 : 0];
                    q_next   = q_reg[(s > 0) ? s - 1 : 0];
                    tex_next = tex_reg[(s > 0) ? s - 1 : 0];
                end
                for (int j = 0; j < 4; j++)
                begin
                    if (s * 4 + j + 1 > SKIP)
                    begin
                        t      = {r_next, 1'b0};
                        b      = t >= {1'b0, denom};
                        r_next = b ? 8'(t - {1'b0, denom}) : t[7:0];
                        q_next = {q_next[31:0], b};
                        if (s * 4 + j + 1 - SKIP == 16)
                            tex_next = q_next[16:0] + {16'd0, r_next >= half_up};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_en[s])
                begin
                    r_reg[s]   <= r_next;
                    q_reg[s]   <= q_next;
                    tex_reg[s] <= tex_next;
                end
            end
        end
    endgenerate

    // Final rounding; the turn count wraps modulo one full turn.
    always_ff @(posedge clk)
    begin
        if (stage_en[STG])
        begin
            angle_reg   <= q_reg[STG-1][31:0] + {31'd0, r_reg[STG-1] >= half_up};
            tex_out_reg <= tex_reg[STG-1];
        end
    end

    assign angle = angle_reg;
    assign tex   = tex_out_reg;

endmodule

### src/uvsg_cordic.sv
// Cosine and sine of a turn angle: quadrant split, scale to radians, then a
// 24-step rotation CORDIC at three steps per stage.
module uvsg_cordic (
    input  logic                                clk,
    input  logic [uvsg_pkg::CORDIC_STAGES-1:0]  stage_en,
    input  logic [31:0]                         angle,
    output logic signed [33:0]                  cos_val,
    output logic signed [33:0]                  sin_val
);

    localparam int ITER_STG = uvsg_pkg::CORDIC_STAGES - 1;
    localparam int PER_STG  = uvsg_pkg::CORDIC_STEPS / ITER_STG;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    logic signed [33:0] z0_reg;
    logic [1:0]         quad_reg [ITER_STG+1];
    logic signed [33:0] x_reg    [ITER_STG];
    logic signed [33:0] y_reg    [ITER_STG];
    logic signed [33:0] z_reg    [ITER_STG];
    logic [60:0]        zprod;

    // Fraction of the quadrant scaled to radians.
    assign zprod = {31'd0, angle[29:0]} * {30'd0, uvsg_pkg::HALF_PI_Q30};

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            z0_reg      <= {3'd0, zprod[60:30]};
            quad_reg[0] <= angle[31:30];
        end
    end

    genvar k;
    generate
        for (k = 0; k < ITER_STG; k++)
        begin : g_iter
            logic signed [33:0] x_next;
            logic signed [33:0] y_next;
            logic signed [33:0] z_next;

            // Three micro-rotations, direction from the sign of the residual.
            always_comb
            begin
                logic signed [33:0] dx;
                logic signed [33:0] dy;
                if (k == 0)
                begin
                    x_next = uvsg_pkg::CORDIC_GAIN_Q30;
                    y_next = '0;
                    z_next = z0_reg;
                end
                else
                begin
                    x_next = x_reg[(k > 0) ? k - 1 : 0];
                    y_next = y_reg[(k > 0) ? k - 1 : 0];
                    z_next = z_reg[(k > 0) ? k - 1 : 0];
                end
                for (int j = 0; j < PER_STG; j++)
                begin
                    dx = y_next >>> (k * PER_STG + j);
                    dy = x_next >>> (k * PER_STG + j);
                    if (!z_next[33])
                    begin
                        x_next = x_next - dx;
                        y_next = y_next + dy;
                        z_next = z_next - uvsg_pkg::atan_q30(k * PER_STG + j);
                    end
                    else
                    begin
                        x_next = x_next + dx;
                        y_next = y_next - dy;
                        z_next = z_next + uvsg_pkg::atan_q30(k * PER_STG + j);
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_en[k+1])
                begin
                    x_reg[k]      <= x_next;
                    y_reg[k]      <= y_next;
                    z_reg[k]      <= z_next;
                    quad_reg[k+1] <= quad_reg[k];
                end
            end
        end
    endgenerate

    // Quadrant fold-back by swapping and negating.
    always_comb
    begin
        case (quad_reg[ITER_STG])
            QUAD_FIRST:
            begin
                cos_val = x_reg[ITER_STG-1];
                sin_val = y_reg[ITER_STG-1];
            end
            QUAD_SECOND:
            begin
                cos_val = -y_reg[ITER_STG-1];
                sin_val = x_reg[ITER_STG-1];
            end
            QUAD_THIRD:
            begin
                cos_val = -x_reg[ITER_STG-1];
                sin_val = -y_reg[ITER_STG-1];
            end
            default:
            begin
                cos_val = y_reg[ITER_STG-1];
                sin_val = -x_reg[ITER_STG-1];
            end
        endcase
    end

endmodule

### src/uvsg_shade.sv
// Normal and position: products, rounding to Q1.15, radius scaling and
// rounding to Q17.7, one step per stage.
module uvsg_shade (
    input  logic                                clk,
    input  logic [uvsg_pkg::SHADE_STAGES-1:0]   stage_en,
    input  logic signed [33:0]                  cos_theta,
    input  logic signed [33:0]                  sin_theta,
    input  logic signed [33:0]                  cos_phi,
    input  logic signed [33:0]                  sin_phi,
    input  logic [15:0]                         radius,
    output logic signed [23:0]                  pos_x,
    output logic signed [23:0]                  pos_y,
    output logic signed [23:0]                  pos_z,
    output logic signed [15:0]                  norm_x,
    output logic signed [15:0]                  norm_y,
    output logic signed [15:0]                  norm_z
);

    logic signed [31:0] ct32;
    logic signed [31:0] st32;
    logic signed [31:0] sp32;
    logic signed [63:0] px_reg;
    logic signed [63:0] pz_reg;
    logic signed [33:0] cp_reg;
    logic signed [63:0] rx_sh;
    logic signed [63:0] rz_sh;
    logic signed [33:0] ry_sh;
    logic signed [15:0] nx_reg [3];
    logic signed [15:0] ny_reg [3];
    logic signed [15:0] nz_reg [3];
    logic signed [32:0] ppx_reg;
    logic signed [32:0] ppy_reg;
    logic signed [32:0] ppz_reg;
    logic signed [32:0] radius_s;
    logic signed [23:0] pos_x_reg;
    logic signed [23:0] pos_y_reg;
    logic signed [23:0] pos_z_reg;

    // The rotated vectors stay inside 32 signed bits.
    assign ct32 = signed'(cos_theta[31:0]);
    assign st32 = signed'(sin_theta[31:0]);
    assign sp32 = signed'(sin_phi[31:0]);

    // Stage one: horizontal products of the normal.
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            px_reg <= ct32 * sp32;
            pz_reg <= st32 * sp32;
            cp_reg <= cos_phi;
        end
    end

    // Stage two: round and saturate the normal to Q1.15.
    assign rx_sh = (px_reg + (64'sd1 <<< 44)) >>> 45;
    assign rz_sh = (pz_reg + (64'sd1 <<< 44)) >>> 45;
    assign ry_sh = (cp_reg + 34'sd16384) >>> 15;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            nx_reg[0] <= uvsg_pkg::sat16(rx_sh[33:0]);
            ny_reg[0] <= uvsg_pkg::sat16(ry_sh);
            nz_reg[0] <= uvsg_pkg::sat16(rz_sh[33:0]);
        end
    end

    // Stage three: scale by the radius.
    assign radius_s = signed'({17'd0, radius});

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            ppx_reg   <= 33'(nx_reg[0]) * radius_s;
            ppy_reg   <= 33'(ny_reg[0]) * radius_s;
            ppz_reg   <= 33'(nz_reg[0]) * radius_s;
            nx_reg[1] <= nx_reg[0];
            ny_reg[1] <= ny_reg[0];
            nz_reg[1] <= nz_reg[0];
        end
    end

    // Stage four: round and saturate the position.
    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            pos_x_reg <= uvsg_pkg::sat24(34'((ppx_reg + 33'sd128) >>> 8));
            pos_y_reg <= uvsg_pkg::sat24(34'((ppy_reg + 33'sd128) >>> 8));
            pos_z_reg <= uvsg_pkg::sat24(34'((ppz_reg + 33'sd128) >>> 8));
            nx_reg[2] <= nx_reg[1];
            ny_reg[2] <= ny_reg[1];
            nz_reg[2] <= nz_reg[1];
        end
    end

    assign pos_x  = pos_x_reg;
    assign pos_y  = pos_y_reg;
    assign pos_z  = pos_z_reg;
    assign norm_x = nx_reg[2];
    assign norm_y = ny_reg[2];
    assign norm_z = nz_reg[2];

endmodule

### src/uv_sphere_vertex_generator_core.sv
// Channel     Handshake               Payload
// input       in_valid / in_ready     ring_index, segment_index
// output      out_valid / out_ready   pos_*, norm_*, tex_*, vertex numbers, flags
// config      cfg_we                  cfg_index, cfg_data
//
// One request enters per cycle unless a stall holds the pipeline; each result
// passes the 22 register stages: 9 for the bit-per-step dividers, 9 for the
// angle scaling and CORDIC, 4 for products, rounding and radius scaling.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage holds only when its successor is full and holding, so a stall
// backs up stage by stage and bubbles are squeezed out.
module uv_sphere_vertex_generator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         ring_index,
    input  logic [7:0]         segment_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] pos_x,
    output logic signed [23:0] pos_y,
    output logic signed [23:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [15:0]        vertex_number,
    output logic [15:0]        lower_row_number,
    output logic               starts_quad,
    output logic               out_of_range,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int L      = uvsg_pkg::PIPE_STAGES;
    localparam int C_BASE = uvsg_pkg::DIV_STAGES;
    localparam int S_BASE = uvsg_pkg::DIV_STAGES + uvsg_pkg::CORDIC_STAGES;

    logic [7:0]  segment_count_reg;
    logic [7:0]  ring_count_reg;
    logic [15:0] sphere_radius_reg;

    logic [L-1:0] valid_reg;
    logic [L:0]   rdy;

    uvsg_pkg::uvsg_side_t side_reg [L];
    uvsg_pkg::uvsg_side_t side_in;
    uvsg_pkg::uvsg_side_t side_tex;

    logic [31:0]        theta;
    logic [31:0]        phi;
    logic [16:0]        tex_u_div;
    logic [16:0]        tex_v_div;
    logic signed [33:0] cos_theta;
    logic signed [33:0] sin_theta;
    logic signed [33:0] cos_phi;
    logic signed [33:0] sin_phi;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [16:0]        vprod;
    logic [15:0]        vnum;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_count_reg <= 8'd32;
            ring_count_reg    <= 8'd16;
            sphere_radius_reg <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uvsg_pkg::REG_SEGMENT_COUNT: segment_count_reg <= cfg_data[7:0];
                uvsg_pkg::REG_RING_COUNT:    ring_count_reg    <= cfg_data[7:0];
                uvsg_pkg::REG_SPHERE_RADIUS: sphere_radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-stage ready: a stage loads when it is empty or its successor loads.
    assign rdy[L] = out_ready;
    genvar i;
    generate
        for (i = 0; i < L; i++)
        begin : g_ready
            assign rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int k = 0; k < L; k++)
            begin
                if (rdy[k])
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k > 0) ? k - 1 : 0];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[L-1];

    // Grid bookkeeping computed on entry.
    assign vprod = {9'd0, ring_index} * ({9'd0, segment_count_reg} + 17'd1);
    assign vnum  = vprod[15:0] + {8'd0, segment_index};

    always_comb
    begin
        side_in.vertex_number    = vnum;
        side_in.lower_row_number = vnum + {8'd0, segment_count_reg} + 16'd1;
        side_in.starts_quad      = (ring_index < ring_count_reg)
                                   && (segment_index < segment_count_reg);
        side_in.out_of_range     = (segment_count_reg == 8'd0) || (ring_count_reg == 8'd0)
                                   || (ring_index > ring_count_reg)
                                   || (segment_index > segment_count_reg);
        side_in.tex_u            = '0;
        side_in.tex_v            = '0;
    end

    // Texture coordinates replace the placeholders once the dividers finish.
    always_comb
    begin
        side_tex       = side_reg[C_BASE-1];
        side_tex.tex_u = tex_u_div;
        side_tex.tex_v = tex_v_div;
    end

    // Side data line; texture coordinates join once the dividers finish.
    generate
        for (i = 0; i < L; i++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (rdy[i])
                begin
                    if (i == 0)
                        side_reg[i] <= side_in;
                    else if (i == C_BASE)
                        side_reg[i] <= side_tex;
                    else
                        side_reg[i] <= side_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    endgenerate

    uvsg_div #(.FRAC(32)) u_div_theta (
        .clk      (clk),
        .stage_en (rdy[C_BASE-1:0]),
        .numer    (segment_index),
        .denom    (segment_count_reg),
        .angle    (theta),
        .tex      (tex_u_div)
    );

    uvsg_div #(.FRAC(31)) u_div_phi (
        .clk      (clk),
        .stage_en (rdy[C_BASE-1:0]),
        .numer    (ring_index),
        .denom    (ring_count_reg),
        .angle    (phi),
        .tex      (tex_v_div)
    );

    uvsg_cordic u_cordic_theta (
        .clk      (clk),
        .stage_en (rdy[S_BASE-1:C_BASE]),
        .angle    (theta),
        .cos_val  (cos_theta),
        .sin_val  (sin_theta)
    );

    uvsg_cordic u_cordic_phi (
        .clk      (clk),
        .stage_en (rdy[S_BASE-1:C_BASE]),
        .angle    (phi),
        .cos_val  (cos_phi),
        .sin_val  (sin_phi)
    );

    uvsg_shade u_shade (
        .clk       (clk),
        .stage_en  (rdy[L-1:S_BASE]),
        .cos_theta (cos_theta),
        .sin_theta (sin_theta),
        .cos_phi   (cos_phi),
        .sin_phi   (sin_phi),
        .radius    (sphere_radius_reg),
        .pos_x     (px),
        .pos_y     (py),
        .pos_z     (pz),
        .norm_x    (nx),
        .norm_y    (ny),
        .norm_z    (nz)
    );

    // Points outside the grid give zeros beside the flag.
    assign pos_x            = side_reg[L-1].out_of_range ? '0 : px;
    assign pos_y            = side_reg[L-1].out_of_range ? '0 : py;
    assign pos_z            = side_reg[L-1].out_of_range ? '0 : pz;
    assign norm_x           = side_reg[L-1].out_of_range ? '0 : nx;
    assign norm_y           = side_reg[L-1].out_of_range ? '0 : ny;
    assign norm_z           = side_reg[L-1].out_of_range ? '0 : nz;
    assign tex_u            = side_reg[L-1].out_of_range ? '0 : side_reg[L-1].tex_u;
    assign tex_v            = side_reg[L-1].out_of_range ? '0 : side_reg[L-1].tex_v;
    assign vertex_number    = side_reg[L-1].out_of_range ? '0 : side_reg[L-1].vertex_number;
    assign lower_row_number = side_reg[L-1].out_of_range ? '0
                                                         : side_reg[L-1].lower_row_number;
    assign starts_quad      = side_reg[L-1].out_of_range ? 1'b0 : side_reg[L-1].starts_quad;
    assign out_of_range     = side_reg[L-1].out_of_range;

endmodule
